FILE: sv/prefixed_float_literal_recognizer_assert.svh
`ifndef PREFIXED_FLOAT_LITERAL_RECOGNIZER_ASSERT_SVH
`define PREFIXED_FLOAT_LITERAL_RECOGNIZER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define PFLR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pflr assertion failed");

// Next-cycle implication, checked on clk, off while rst is high.
`define PFLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pflr assertion failed");

`endif

FILE: sv/pflr_pkg.sv
`timescale 1ns / 1ps

package pflr_pkg;

  localparam logic [15:0] CH_UPPER_D = 16'h0044;
  localparam logic [15:0] CH_LOWER_D = 16'h0064;
  localparam logic [15:0] CH_UPPER_S = 16'h0053;
  localparam logic [15:0] CH_LOWER_E = 16'h0065;
  localparam logic [15:0] CH_UPPER_E = 16'h0045;
  localparam logic [15:0] CH_DOT     = 16'h002E;
  localparam logic [15:0] CH_PLUS    = 16'h002B;
  localparam logic [15:0] CH_MINUS   = 16'h002D;
  localparam logic [15:0] CH_NUL     = 16'h0000;
  localparam logic [15:0] CH_N       = 16'h004E;
  localparam logic [15:0] CH_A       = 16'h0041;
  localparam logic [15:0] CH_I       = 16'h0049;
  localparam logic [15:0] CH_F       = 16'h0046;
  localparam logic [15:0] CH_T       = 16'h0054;
  localparam logic [15:0] CH_Y       = 16'h0059;

  localparam logic [1:0] UNITS_NONE  = 2'd0;
  localparam logic [1:0] UNITS_FIRST = 2'd1;
  localparam logic [1:0] UNITS_MORE  = 2'd2;

  typedef enum logic [3:0] {
    NP_LEAD    = 4'd0,
    NP_SIGN    = 4'd1,
    NP_INT     = 4'd2,
    NP_FRAC    = 4'd3,
    NP_EXP     = 4'd4,
    NP_EXPSIGN = 4'd5,
    NP_EXPDIG  = 4'd6,
    NP_TRAIL   = 4'd7,
    NP_NULS    = 4'd8,
    NP_DEAD    = 4'd9
  } number_phase_t;

  typedef enum logic [3:0] {
    SP_LEAD     = 4'd0,
    SP_SIGNED   = 4'd1,
    SP_N        = 4'd2,
    SP_NA       = 4'd3,
    SP_NAN      = 4'd4,
    SP_I        = 4'd5,
    SP_IN       = 4'd6,
    SP_INF      = 4'd7,
    SP_INFI     = 4'd8,
    SP_INFIN    = 4'd9,
    SP_INFINI   = 4'd10,
    SP_INFINIT  = 4'd11,
    SP_INFINITY = 4'd12,
    SP_DEAD     = 4'd14
  } special_phase_t;

  typedef struct packed {
    logic [1:0]     units_seen;
    logic           prefix_valid;
    number_phase_t  number_phase;
    logic           any_digit;
    special_phase_t special_phase;
  } scan_state_t;

  localparam scan_state_t STATE_RESET = '{
    units_seen:    UNITS_NONE,
    prefix_valid:  1'b0,
    number_phase:  NP_LEAD,
    any_digit:     1'b0,
    special_phase: SP_LEAD
  };

endpackage

FILE: sv/pflr_step.sv
`timescale 1ns / 1ps

module pflr_step (
  input  pflr_pkg::scan_state_t st,
  input  logic [15:0]           code_unit,
  output pflr_pkg::scan_state_t st_next,
  output logic                  ok
);

  function automatic logic ascii_ws(input logic [15:0] c);
    return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
  endfunction

  function automatic logic unicode_ws(input logic [15:0] c);
    return ascii_ws(c) || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
           (c >= 16'h2000 && c <= 16'h200A) || c == 16'h2028 || c == 16'h2029 ||
           c == 16'h202F || c == 16'h205F || c == 16'h3000;
  endfunction

  logic                     dig;
  logic                     sgn;
  logic                     ex;
  logic                     dot;
  logic                     nul;
  logic                     aws;
  logic                     uws;
  logic [15:0]              up;
  pflr_pkg::number_phase_t  np_next;
  logic                     ad_next;
  pflr_pkg::special_phase_t sp_next;
  logic                     num_ok;

  assign dig = code_unit >= 16'h0030 && code_unit <= 16'h0039;
  assign sgn = code_unit == pflr_pkg::CH_PLUS || code_unit == pflr_pkg::CH_MINUS;
  assign ex  = code_unit == pflr_pkg::CH_LOWER_E || code_unit == pflr_pkg::CH_UPPER_E;
  assign dot = code_unit == pflr_pkg::CH_DOT;
  assign nul = code_unit == pflr_pkg::CH_NUL;
  assign aws = ascii_ws(code_unit);
  assign uws = unicode_ws(code_unit);
  assign up  = (code_unit >= 16'h0061 && code_unit <= 16'h007A) ?
               code_unit - 16'h0020 : code_unit;

  always_comb begin
    np_next = pflr_pkg::NP_DEAD;
    ad_next = st.any_digit;
    unique case (st.number_phase)
      pflr_pkg::NP_LEAD: begin
        priority if (aws) np_next = pflr_pkg::NP_LEAD;
        else if (sgn) np_next = pflr_pkg::NP_SIGN;
        else if (dig) begin
          np_next = pflr_pkg::NP_INT;
          ad_next = 1'b1;
        end else if (dot) np_next = pflr_pkg::NP_FRAC;
        else np_next = pflr_pkg::NP_DEAD;
      end
      pflr_pkg::NP_SIGN: begin
        priority if (dig) begin
          np_next = pflr_pkg::NP_INT;
          ad_next = 1'b1;
        end else if (dot) np_next = pflr_pkg::NP_FRAC;
        else np_next = pflr_pkg::NP_DEAD;
      end
      pflr_pkg::NP_INT, pflr_pkg::NP_FRAC: begin
        priority if (dig) begin
          np_next = st.number_phase;
          ad_next = 1'b1;
        end else if (st.number_phase == pflr_pkg::NP_INT && dot) begin
          np_next = pflr_pkg::NP_FRAC;
        end else if (!st.any_digit) np_next = pflr_pkg::NP_DEAD;
        else if (ex) np_next = pflr_pkg::NP_EXP;
        else if (aws) np_next = pflr_pkg::NP_TRAIL;
        else if (nul) np_next = pflr_pkg::NP_NULS;
        else np_next = pflr_pkg::NP_DEAD;
      end
      pflr_pkg::NP_EXP: begin
        priority if (sgn) np_next = pflr_pkg::NP_EXPSIGN;
        else if (dig) np_next = pflr_pkg::NP_EXPDIG;
        else np_next = pflr_pkg::NP_DEAD;
      end
      pflr_pkg::NP_EXPSIGN: begin
        if (dig) np_next = pflr_pkg::NP_EXPDIG;
      end
      pflr_pkg::NP_EXPDIG: begin
        priority if (dig) np_next = pflr_pkg::NP_EXPDIG;
        else if (aws) np_next = pflr_pkg::NP_TRAIL;
        else if (nul) np_next = pflr_pkg::NP_NULS;
        else np_next = pflr_pkg::NP_DEAD;
      end
      pflr_pkg::NP_TRAIL: begin
        priority if (aws) np_next = pflr_pkg::NP_TRAIL;
        else if (nul) np_next = pflr_pkg::NP_NULS;
        else np_next = pflr_pkg::NP_DEAD;
      end
      pflr_pkg::NP_NULS: begin
        if (nul) np_next = pflr_pkg::NP_NULS;
      end
      default: np_next = pflr_pkg::NP_DEAD;
    endcase
  end

  always_comb begin
    sp_next = pflr_pkg::SP_DEAD;
    unique case (st.special_phase)
      pflr_pkg::SP_LEAD, pflr_pkg::SP_SIGNED: begin
        priority if (st.special_phase == pflr_pkg::SP_LEAD && uws) begin
          sp_next = pflr_pkg::SP_LEAD;
        end else if (st.special_phase == pflr_pkg::SP_LEAD && sgn) begin
          sp_next = pflr_pkg::SP_SIGNED;
        end else if (up == pflr_pkg::CH_N) sp_next = pflr_pkg::SP_N;
        else if (up == pflr_pkg::CH_I) sp_next = pflr_pkg::SP_I;
        else sp_next = pflr_pkg::SP_DEAD;
      end
      pflr_pkg::SP_N:       if (up == pflr_pkg::CH_A) sp_next = pflr_pkg::SP_NA;
      pflr_pkg::SP_NA:      if (up == pflr_pkg::CH_N) sp_next = pflr_pkg::SP_NAN;
      pflr_pkg::SP_I:       if (up == pflr_pkg::CH_N) sp_next = pflr_pkg::SP_IN;
      pflr_pkg::SP_IN:      if (up == pflr_pkg::CH_F) sp_next = pflr_pkg::SP_INF;
      pflr_pkg::SP_INF:     if (up == pflr_pkg::CH_I) sp_next = pflr_pkg::SP_INFI;
      pflr_pkg::SP_INFI:    if (up == pflr_pkg::CH_N) sp_next = pflr_pkg::SP_INFIN;
      pflr_pkg::SP_INFIN:   if (up == pflr_pkg::CH_I) sp_next = pflr_pkg::SP_INFINI;
      pflr_pkg::SP_INFINI:  if (up == pflr_pkg::CH_T) sp_next = pflr_pkg::SP_INFINIT;
      pflr_pkg::SP_INFINIT: if (up == pflr_pkg::CH_Y) sp_next = pflr_pkg::SP_INFINITY;
      pflr_pkg::SP_NAN, pflr_pkg::SP_INFINITY: begin
        if (uws) sp_next = st.special_phase;
      end
      default: sp_next = pflr_pkg::SP_DEAD;
    endcase
  end

  always_comb begin
    st_next = st;
    if (st.units_seen == pflr_pkg::UNITS_NONE) begin
      st_next.prefix_valid = code_unit == pflr_pkg::CH_UPPER_D ||
                             code_unit == pflr_pkg::CH_LOWER_D ||
                             code_unit == pflr_pkg::CH_UPPER_S;
      st_next.units_seen   = pflr_pkg::UNITS_FIRST;
    end else begin
      st_next.number_phase  = np_next;
      st_next.any_digit     = ad_next;
      st_next.special_phase = sp_next;
      st_next.units_seen    = pflr_pkg::UNITS_MORE;
    end
  end

  assign num_ok = st_next.any_digit &&
                  (st_next.number_phase == pflr_pkg::NP_INT ||
                   st_next.number_phase == pflr_pkg::NP_FRAC ||
                   st_next.number_phase == pflr_pkg::NP_EXPDIG ||
                   st_next.number_phase == pflr_pkg::NP_TRAIL ||
                   st_next.number_phase == pflr_pkg::NP_NULS);

  assign ok = st_next.prefix_valid && st_next.units_seen == pflr_pkg::UNITS_MORE &&
              (num_ok || st_next.special_phase == pflr_pkg::SP_NAN ||
               st_next.special_phase == pflr_pkg::SP_INFINITY);

endmodule

FILE: sv/prefixed_float_literal_recognizer.sv
// Prefixed float literal recognizer.
// Input channel: in_valid / in_ready carry one UTF-16 code unit per beat in
// code_unit, with last high on the final unit of a string. The first unit is
// the prefix (D, d or S); the rest must be a decimal float literal or an optionally
// signed NAN / INFINITY with surrounding whitespace.
// Output channel: out_valid / out_ready carry one beat per string, accepted.
// Unmarked units produce no beat.
// Throughput: one unit per cycle, except during the stall below; the per-unit scan is a single
// stage of small FSM logic between the input register and the scan state.
// Result: the result of a string is loaded into the output register when its
// last unit leaves the input register and the output register is free.
// Stall: while a result waits in the output register, units that are not the
// end of a string still advance; a second last unit holds in the input
// register and in_ready drops until out_ready takes the pending beat.
// Reset: rst (synchronous) empties both registers and returns the scan state
// to the start of a string. After each result the scan state restarts too.
`timescale 1ns / 1ps
`include "prefixed_float_literal_recognizer_assert.svh"

module prefixed_float_literal_recognizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted
);

  logic                  s0_valid;
  logic [15:0]           s0_code;
  logic                  s0_last;
  logic                  s0_adv;
  pflr_pkg::scan_state_t st;
  pflr_pkg::scan_state_t st_next;
  logic                  ok;

  assign s0_adv   = s0_valid && (!s0_last || !out_valid || out_ready);
  assign in_ready = !s0_valid || s0_adv;

  pflr_step u_step (
    .st        (st),
    .code_unit (s0_code),
    .st_next   (st_next),
    .ok        (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= pflr_pkg::STATE_RESET;
    end else begin
      if (in_ready) s0_valid <= in_valid;
      if (s0_adv) st <= s0_last ? pflr_pkg::STATE_RESET : st_next;
      if (s0_adv && s0_last) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_code <= code_unit;
      s0_last <= last;
    end
    if (s0_adv && s0_last) accepted <= ok;
  end

  `PFLR_ASSERT_NEXT(a_restart, s0_adv && s0_last, st.units_seen == pflr_pkg::UNITS_NONE)
  `PFLR_ASSERT_NOW(a_stall_cause, !in_ready, s0_valid && s0_last && out_valid && !out_ready)
  `PFLR_ASSERT_NOW(a_units_range, 1'b1, st.units_seen != 2'd3)
  `PFLR_ASSERT_NEXT(a_single_unit,
                    s0_adv && s0_last && st.units_seen == pflr_pkg::UNITS_NONE,
                    out_valid && !accepted)

endmodule
